### rtl/core/i2cb_pkg.sv
// Shared types and constants for the I2C slave command FIFO bridge.
`timescale 1ns / 1ps

package i2cb_pkg;

  localparam int RX_DEPTH_DEF  = 4096;
  localparam int TX_DEPTH_DEF  = 16384;
  localparam int CHUNK_MAX_DEF = 1024;

  localparam int FQ_DEPTH = 2;
  localparam int OQ_DEPTH = 4;

  localparam int  CFG_AW     = 3;
  localparam logic REG_ENABLE = 1'b0;

  localparam logic [7:0] PREFIX_BYTE = 8'h10;
  localparam logic [7:0] CMD_READ    = 8'h01;
  localparam logic [7:0] CMD_WRITE   = 8'h02;
  localparam logic [7:0] CMD_AVAIL   = 8'h03;
  localparam logic [7:0] CMD_RESET   = 8'h06;

  typedef enum logic [1:0] {
    REQ_MWRITE = 2'd0,
    REQ_MREAD  = 2'd1,
    REQ_HPUSH  = 2'd2,
    REQ_HPOP   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    CLS_OTHER  = 3'd0,
    CLS_PREFIX = 3'd1,
    CLS_READ   = 3'd2,
    CLS_WRITE  = 3'd3,
    CLS_AVAIL  = 3'd4,
    CLS_RESET  = 3'd5
  } cls_e;

  typedef struct packed {
    req_e       req;
    cls_e       cls;
    logic [7:0] data;
  } item_t;

endpackage

### rtl/core/i2cb_front.sv
// Front end: accepts input transfers, classifies bytes and queues them.
`timescale 1ns / 1ps

module i2cb_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      req_type_i,
  input  logic [7:0]      data_i,
  output logic            item_valid_o,
  input  logic            item_ready_i,
  output i2cb_pkg::item_t item_o
);
  import i2cb_pkg::*;

  localparam int PW = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
  localparam int CW = $clog2(FQ_DEPTH + 1);

  item_t          q_mem [FQ_DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  item_t          new_item;
  cls_e           cls;
  logic           push, pop;

  always_comb begin
    unique case (data_i)
      PREFIX_BYTE: cls = CLS_PREFIX;
      CMD_READ:    cls = CLS_READ;
      CMD_WRITE:   cls = CLS_WRITE;
      CMD_AVAIL:   cls = CLS_AVAIL;
      CMD_RESET:   cls = CLS_RESET;
      default:     cls = CLS_OTHER;
    endcase
  end

  assign new_item.req  = req_e'(req_type_i);
  assign new_item.cls  = cls;
  assign new_item.data = data_i;

  assign in_ready_o   = (cnt_q != CW'(FQ_DEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = q_mem[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(FQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(FQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= new_item;
    end
  end

endmodule

### rtl/core/i2cb_exec.sv
// Back end: frame parser, RX and TX byte stores and the result stage.
`timescale 1ns / 1ps

module i2cb_exec #(
  parameter int RX_DEPTH  = i2cb_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH  = i2cb_pkg::TX_DEPTH_DEF,
  parameter int CHUNK_MAX = i2cb_pkg::CHUNK_MAX_DEF,
  parameter int RES_W     = 11 + $clog2(RX_DEPTH + 1) + $clog2(TX_DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               enable_i,
  input  logic               clear_i,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  input  i2cb_pkg::item_t    item_i,
  input  logic [$clog2(i2cb_pkg::OQ_DEPTH+1)-1:0] oq_cnt_i,
  output logic               res_valid_o,
  output logic [RES_W-1:0]   res_o
);
  import i2cb_pkg::*;

  localparam int RXAW = $clog2(RX_DEPTH);
  localparam int RXCW = $clog2(RX_DEPTH + 1);
  localparam int TXAW = $clog2(TX_DEPTH);
  localparam int TXCW = $clog2(TX_DEPTH + 1);
  localparam int PCW  = ($clog2(CHUNK_MAX + 1) > 2) ? $clog2(CHUNK_MAX + 1) : 2;
  localparam int OQCW = $clog2(OQ_DEPTH + 1);
  localparam logic [15:0] CHUNK16 = 16'(CHUNK_MAX);

  localparam logic [2:0] PH_PREFIX  = 3'd0;
  localparam logic [2:0] PH_CMD     = 3'd1;
  localparam logic [2:0] PH_RLEN_HI = 3'd2;
  localparam logic [2:0] PH_RLEN_LO = 3'd3;
  localparam logic [2:0] PH_WLEN_HI = 3'd4;
  localparam logic [2:0] PH_WLEN_LO = 3'd5;
  localparam logic [2:0] PH_WDATA   = 3'd6;

  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_READ  = 2'd1;
  localparam logic [1:0] PEND_AVAIL = 2'd2;

  localparam logic [1:0] SEL_NONE  = 2'd0;
  localparam logic [1:0] SEL_RX    = 2'd1;
  localparam logic [1:0] SEL_TX    = 2'd2;
  localparam logic [1:0] SEL_AVAIL = 2'd3;

  logic [7:0]      rx_mem [RX_DEPTH];
  logic [7:0]      tx_mem [TX_DEPTH];
  logic [7:0]      rx_rd_q, tx_rd_q;

  logic [2:0]      phase_q, phase_d;
  logic [15:0]     flen_q, flen_d;
  logic [1:0]      pkind_q, pkind_d;
  logic [PCW-1:0]  pcount_q, pcount_d;
  logic [15:0]     snap_q, snap_d;
  logic [RXAW-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [RXCW-1:0] rx_cnt_q, rx_cnt_d;
  logic [TXAW-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [TXCW-1:0] tx_cnt_q, tx_cnt_d;

  logic            issue, rx_we, rx_re, tx_we, tx_re;
  logic            r_valid, r_acc, r_err;
  logic [1:0]      r_sel;
  logic [7:0]      r_byte;
  logic [15:0]     len, len_cap;
  logic [16:0]     n_sel;
  logic            tx_ok;

  logic            s2_v_q;
  logic            s2_valid_q, s2_acc_q, s2_err_q;
  logic [1:0]      s2_sel_q;
  logic [7:0]      s2_byte_q;
  logic [RXCW-1:0] s2_rx_lvl_q;
  logic [TXCW-1:0] s2_tx_lvl_q;
  logic [7:0]      out_byte;

  assign item_ready_o = ((OQCW + 1)'(oq_cnt_i) + (OQCW + 1)'(s2_v_q)) < (OQCW + 1)'(OQ_DEPTH);
  assign issue        = item_valid_i && item_ready_o;

  assign len     = flen_q | {8'h00, item_i.data};
  assign len_cap = (len > CHUNK16) ? CHUNK16 : len;
  assign n_sel   = (17'(len_cap) > 17'(tx_cnt_q)) ? 17'(tx_cnt_q) : 17'(len_cap);

  always_comb begin
    phase_d   = phase_q;
    flen_d    = flen_q;
    pkind_d   = pkind_q;
    pcount_d  = pcount_q;
    snap_d    = snap_q;
    rx_head_d = rx_head_q;
    rx_tail_d = rx_tail_q;
    rx_cnt_d  = rx_cnt_q;
    tx_head_d = tx_head_q;
    tx_tail_d = tx_tail_q;
    tx_cnt_d  = tx_cnt_q;
    rx_we     = 1'b0;
    rx_re     = 1'b0;
    tx_we     = 1'b0;
    tx_re     = 1'b0;
    r_valid   = 1'b0;
    r_acc     = 1'b0;
    r_err     = 1'b0;
    r_sel     = SEL_NONE;
    r_byte    = 8'h00;
    tx_ok     = (tx_cnt_q != '0);

    if (issue && enable_i) begin
      case (item_i.req)
        REQ_MWRITE: begin
          unique case (phase_q)
            PH_PREFIX: begin
              if (item_i.cls == CLS_PREFIX) phase_d = PH_CMD;
            end
            PH_CMD: begin
              phase_d = PH_PREFIX;
              unique case (item_i.cls)
                CLS_READ:  phase_d = PH_RLEN_HI;
                CLS_WRITE: phase_d = PH_WLEN_HI;
                CLS_AVAIL: begin
                  snap_d   = 16'(tx_cnt_q);
                  pkind_d  = PEND_AVAIL;
                  pcount_d = PCW'(2);
                end
                CLS_RESET: begin
                  rx_head_d = '0;
                  rx_tail_d = '0;
                  rx_cnt_d  = '0;
                  tx_head_d = '0;
                  tx_tail_d = '0;
                  tx_cnt_d  = '0;
                  pkind_d   = PEND_NONE;
                  pcount_d  = '0;
                end
                default:   r_err = 1'b1;
              endcase
            end
            PH_RLEN_HI, PH_WLEN_HI: begin
              flen_d  = {item_i.data, 8'h00};
              phase_d = phase_q + 3'd1;
            end
            PH_RLEN_LO: begin
              pcount_d = PCW'(n_sel);
              pkind_d  = (n_sel != '0) ? PEND_READ : PEND_NONE;
              flen_d   = '0;
              phase_d  = PH_PREFIX;
            end
            PH_WLEN_LO: begin
              flen_d  = len_cap;
              phase_d = (len_cap != '0) ? PH_WDATA : PH_PREFIX;
            end
            PH_WDATA: begin
              if (rx_cnt_q < RXCW'(RX_DEPTH)) begin
                rx_we     = 1'b1;
                rx_tail_d = (rx_tail_q == RXAW'(RX_DEPTH - 1)) ? '0 : rx_tail_q + 1'b1;
                rx_cnt_d  = rx_cnt_q + 1'b1;
                r_acc     = 1'b1;
              end
              if (flen_q != '0) flen_d = flen_q - 16'd1;
              if (flen_q <= 16'd1) phase_d = PH_PREFIX;
            end
            default: phase_d = PH_PREFIX;
          endcase
        end
        REQ_MREAD: begin
          if (pkind_q == PEND_AVAIL && pcount_q != '0) begin
            r_valid  = 1'b1;
            r_sel    = SEL_AVAIL;
            r_byte   = (pcount_q == PCW'(2)) ? snap_q[15:8] : snap_q[7:0];
            pcount_d = pcount_q - 1'b1;
            if (pcount_q == PCW'(1)) pkind_d = PEND_NONE;
          end else if (pkind_q == PEND_READ && pcount_q != '0) begin
            if (tx_ok) begin
              tx_re     = 1'b1;
              tx_head_d = (tx_head_q == TXAW'(TX_DEPTH - 1)) ? '0 : tx_head_q + 1'b1;
              tx_cnt_d  = tx_cnt_q - 1'b1;
              r_valid   = 1'b1;
              r_sel     = SEL_TX;
              pcount_d  = pcount_q - 1'b1;
              if (pcount_q == PCW'(1)) pkind_d = PEND_NONE;
            end else begin
              pcount_d = '0;
              pkind_d  = PEND_NONE;
            end
          end else begin
            pkind_d  = PEND_NONE;
            pcount_d = '0;
          end
        end
        REQ_HPUSH: begin
          if (tx_cnt_q < TXCW'(TX_DEPTH)) begin
            tx_we     = 1'b1;
            tx_tail_d = (tx_tail_q == TXAW'(TX_DEPTH - 1)) ? '0 : tx_tail_q + 1'b1;
            tx_cnt_d  = tx_cnt_q + 1'b1;
            r_acc     = 1'b1;
          end
        end
        default: begin
          if (rx_cnt_q != '0) begin
            rx_re     = 1'b1;
            rx_head_d = (rx_head_q == RXAW'(RX_DEPTH - 1)) ? '0 : rx_head_q + 1'b1;
            rx_cnt_d  = rx_cnt_q - 1'b1;
            r_valid   = 1'b1;
            r_sel     = SEL_RX;
          end
        end
      endcase
    end

    if (clear_i) begin
      phase_d   = PH_PREFIX;
      flen_d    = '0;
      pkind_d   = PEND_NONE;
      pcount_d  = '0;
      snap_d    = '0;
      rx_head_d = '0;
      rx_tail_d = '0;
      rx_cnt_d  = '0;
      tx_head_d = '0;
      tx_tail_d = '0;
      tx_cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_PREFIX;
      flen_q    <= '0;
      pkind_q   <= PEND_NONE;
      pcount_q  <= '0;
      snap_q    <= '0;
      rx_head_q <= '0;
      rx_tail_q <= '0;
      rx_cnt_q  <= '0;
      tx_head_q <= '0;
      tx_tail_q <= '0;
      tx_cnt_q  <= '0;
      s2_v_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      flen_q    <= flen_d;
      pkind_q   <= pkind_d;
      pcount_q  <= pcount_d;
      snap_q    <= snap_d;
      rx_head_q <= rx_head_d;
      rx_tail_q <= rx_tail_d;
      rx_cnt_q  <= rx_cnt_d;
      tx_head_q <= tx_head_d;
      tx_tail_q <= tx_tail_d;
      tx_cnt_q  <= tx_cnt_d;
      s2_v_q    <= issue;
    end
  end

  // result stage payload, aligned with the store read data
  always_ff @(posedge clk_i) begin
    if (issue) begin
      s2_valid_q  <= r_valid;
      s2_acc_q    <= r_acc;
      s2_err_q    <= r_err;
      s2_sel_q    <= r_sel;
      s2_byte_q   <= r_byte;
      s2_rx_lvl_q <= rx_cnt_d;
      s2_tx_lvl_q <= tx_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_we) begin
      rx_mem[rx_tail_q] <= item_i.data;
    end
    if (rx_re) begin
      rx_rd_q <= rx_mem[rx_head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tx_we) begin
      tx_mem[tx_tail_q] <= item_i.data;
    end
    if (tx_re) begin
      tx_rd_q <= tx_mem[tx_head_q];
    end
  end

  always_comb begin
    case (s2_sel_q)
      SEL_RX:    out_byte = rx_rd_q;
      SEL_TX:    out_byte = tx_rd_q;
      SEL_AVAIL: out_byte = s2_byte_q;
      default:   out_byte = 8'h00;
    endcase
    if (!s2_valid_q) out_byte = 8'h00;
  end

  assign res_valid_o = s2_v_q;
  assign res_o       = {s2_valid_q, out_byte, s2_acc_q, s2_err_q, s2_rx_lvl_q, s2_tx_lvl_q};

endmodule

### rtl/core/i2cb_outq.sv
// Result queue in front of the output channel.
`timescale 1ns / 1ps

module i2cb_outq #(
  parameter int W = 39
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    push_i,
  input  logic [W-1:0]                            data_i,
  output logic [$clog2(i2cb_pkg::OQ_DEPTH+1)-1:0] cnt_o,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [W-1:0]                            data_o
);
  import i2cb_pkg::*;

  localparam int PW = $clog2(OQ_DEPTH);
  localparam int CW = $clog2(OQ_DEPTH + 1);

  logic [W-1:0]  q_mem [OQ_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pop;

  assign out_valid_o = (cnt_q != '0);
  assign data_o      = q_mem[rd_ptr_q];
  assign cnt_o       = cnt_q;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(OQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(OQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_mem[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/core/i2c_slave_command_fifo_bridge_top.sv
// Top level of the I2C slave command FIFO bridge with its register port.
`timescale 1ns / 1ps

// Usage:
// - Input channel (in_valid_i/in_ready_o) carries one request per transfer:
//   master byte write, master byte read, host TX push or host RX pop.
// - Output channel (out_valid_o/out_ready_i) returns exactly one result per
//   request, in order: read byte, store flag, command error, FIFO levels.
// - Register 0 (byte address 0) is interface_enable. While it is 0 every
//   request is ignored; writing 0 clears the parser and both FIFOs.
// - An input transfer reaches out_valid_o through the front queue, the
//   parser/store access and the store read register into the result
//   queue.
// - Throughput is one request per cycle while the result queue has room;
//   the parser and each byte store handle one access per cycle.
// - A stalled output fills the 4-entry result queue, then the 2-entry
//   front queue, after which in_ready_o drops; nothing is lost.
// - After reset both FIFOs are empty and the interface is disabled. Store
//   contents are not cleared; only written entries are ever read.
module i2c_slave_command_fifo_bridge_top #(
  parameter int RX_DEPTH  = i2cb_pkg::RX_DEPTH_DEF,
  parameter int TX_DEPTH  = i2cb_pkg::TX_DEPTH_DEF,
  parameter int CHUNK_MAX = i2cb_pkg::CHUNK_MAX_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [i2cb_pkg::CFG_AW-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        req_type_i,
  input  logic [7:0]                        data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              resp_valid_o,
  output logic [7:0]                        resp_data_o,
  output logic                              accepted_o,
  output logic                              cmd_error_o,
  output logic [$clog2(RX_DEPTH+1)-1:0]     rx_level_o,
  output logic [$clog2(TX_DEPTH+1)-1:0]     tx_level_o
);
  import i2cb_pkg::*;

  localparam int RXCW  = $clog2(RX_DEPTH + 1);
  localparam int TXCW  = $clog2(TX_DEPTH + 1);
  localparam int RES_W = 11 + RXCW + TXCW;

  logic                           enable_q, enable_d;
  logic                           reg_wr, clear;
  item_t                          item;
  logic                           item_valid, item_ready;
  logic                           res_valid;
  logic [RES_W-1:0]               res, out_res;
  logic [$clog2(OQ_DEPTH+1)-1:0]  oq_cnt;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && (paddr[CFG_AW-1] == REG_ENABLE);
  assign clear  = reg_wr && !pwdata[0];
  assign prdata = (paddr[CFG_AW-1] == REG_ENABLE) ? {31'b0, enable_q} : 32'b0;

  always_comb begin
    enable_d = enable_q;
    if (reg_wr) enable_d = pwdata[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else begin
      enable_q <= enable_d;
    end
  end

  i2cb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .data_i       (data_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  i2cb_exec #(
    .RX_DEPTH  (RX_DEPTH),
    .TX_DEPTH  (TX_DEPTH),
    .CHUNK_MAX (CHUNK_MAX),
    .RES_W     (RES_W)
  ) u_exec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .enable_i     (enable_q),
    .clear_i      (clear),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .oq_cnt_i     (oq_cnt),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  i2cb_outq #(
    .W (RES_W)
  ) u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .data_i      (res),
    .cnt_o       (oq_cnt),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (out_res)
  );

  assign {resp_valid_o, resp_data_o, accepted_o, cmd_error_o, rx_level_o, tx_level_o} = out_res;

endmodule

### verif/i2c_slave_command_fifo_bridge_top_test.sv
// Self-checking testbench for the I2C slave command FIFO bridge with random traffic.
`timescale 1ns / 1ps

module i2c_slave_command_fifo_bridge_top_test;
  import i2cb_pkg::*;

  localparam int RXD       = RX_DEPTH_DEF;
  localparam int TXD       = TX_DEPTH_DEF;
  localparam int CHUNK     = CHUNK_MAX_DEF;
  localparam int RXW       = $clog2(RXD + 1);
  localparam int TXW       = $clog2(TXD + 1);
  localparam int LATENCY   = 3;
  localparam int LONG_HOLD = 200;

  typedef enum logic [2:0] {
    PH_PREFIX, PH_CMD, PH_RLEN_HI, PH_RLEN_LO, PH_WLEN_HI, PH_WLEN_LO, PH_WDATA
  } parse_phase_e;

  typedef enum logic [1:0] {
    PEND_NONE, PEND_READ, PEND_AVAIL
  } pend_kind_e;

  typedef struct packed {
    req_e       req;
    logic [7:0] data;
  } bridge_req_t;

  typedef struct packed {
    logic           resp_valid;
    logic [7:0]     resp_data;
    logic           accepted;
    logic           cmd_error;
    logic [RXW-1:0] rx_level;
    logic [TXW-1:0] tx_level;
  } bridge_resp_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [CFG_AW-1:0]   paddr       = '0;
  logic [31:0]         pwdata      = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [1:0]          req_type_i  = '0;
  logic [7:0]          data_i      = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                resp_valid_o;
  logic [7:0]          resp_data_o;
  logic                accepted_o;
  logic                cmd_error_o;
  logic [RXW-1:0]      rx_level_o;
  logic [TXW-1:0]      tx_level_o;

  bridge_req_t  req_q[$];
  bridge_resp_t resp_q[$];
  int unsigned  errors        = 0;
  int unsigned  n_queued      = 0;
  int unsigned  n_xfer        = 0;
  int unsigned  n_seen        = 0;
  int           send_idle_pct = 14;
  int           recv_idle_pct = 57;
  int unsigned  hold_req      = 0;
  int unsigned  hold_done     = 0;
  int           hold_left     = 0;

  // bridge state mirror
  logic         enabled    = 1'b0;
  parse_phase_e phase      = PH_PREFIX;
  logic [15:0]  frame_len  = '0;
  pend_kind_e   pend       = PEND_NONE;
  int           pend_cnt   = 0;
  logic [15:0]  avail_snap = '0;
  logic [7:0]   rx_store[RXD];
  logic [7:0]   tx_store[TXD];
  int           rx_head = 0, rx_tail = 0, rx_count = 0;
  int           tx_head = 0, tx_tail = 0, tx_count = 0;

  i2c_slave_command_fifo_bridge_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .data_i      (data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .resp_valid_o(resp_valid_o),
    .resp_data_o (resp_data_o),
    .accepted_o  (accepted_o),
    .cmd_error_o (cmd_error_o),
    .rx_level_o  (rx_level_o),
    .tx_level_o  (tx_level_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic bridge_resp_t bridge_step(req_e req, logic [7:0] b);
    bridge_resp_t r;
    int n;
    r = '0;
    if (enabled) begin
      case (req)
        REQ_MWRITE: begin
          case (phase)
            PH_PREFIX: if (b == PREFIX_BYTE) phase = PH_CMD;
            PH_CMD: begin
              phase = PH_PREFIX;
              case (b)
                CMD_READ:  phase = PH_RLEN_HI;
                CMD_WRITE: phase = PH_WLEN_HI;
                CMD_AVAIL: begin
                  avail_snap = tx_count[15:0];
                  pend = PEND_AVAIL;
                  pend_cnt = 2;
                end
                CMD_RESET: begin
                  rx_head = 0; rx_tail = 0; rx_count = 0;
                  tx_head = 0; tx_tail = 0; tx_count = 0;
                  pend = PEND_NONE;
                  pend_cnt = 0;
                end
                default: r.cmd_error = 1'b1;
              endcase
            end
            PH_RLEN_HI: begin
              frame_len = {b, 8'h00};
              phase = PH_RLEN_LO;
            end
            PH_WLEN_HI: begin
              frame_len = {b, 8'h00};
              phase = PH_WLEN_LO;
            end
            PH_RLEN_LO: begin
              n = {frame_len[15:8], b};
              if (n > CHUNK) n = CHUNK;
              if (n > tx_count) n = tx_count;
              pend = (n != 0) ? PEND_READ : PEND_NONE;
              pend_cnt = n;
              frame_len = '0;
              phase = PH_PREFIX;
            end
            PH_WLEN_LO: begin
              frame_len = {frame_len[15:8], b};
              if (frame_len > CHUNK) frame_len = 16'(CHUNK);
              phase = (frame_len != 0) ? PH_WDATA : PH_PREFIX;
            end
            PH_WDATA: begin
              if (rx_count < RXD) begin
                rx_store[rx_tail] = b;
                rx_tail = (rx_tail + 1) % RXD;
                rx_count++;
                r.accepted = 1'b1;
              end
              if (frame_len > 0) frame_len--;
              if (frame_len == 0) phase = PH_PREFIX;
            end
            default: phase = PH_PREFIX;
          endcase
        end
        REQ_MREAD: begin
          if (pend == PEND_AVAIL && pend_cnt > 0) begin
            r.resp_valid = 1'b1;
            r.resp_data = (pend_cnt == 2) ? avail_snap[15:8] : avail_snap[7:0];
            pend_cnt--;
            if (pend_cnt == 0) pend = PEND_NONE;
          end else if (pend == PEND_READ && pend_cnt > 0) begin
            pend_cnt--;
            if (tx_count > 0) begin
              r.resp_valid = 1'b1;
              r.resp_data = tx_store[tx_head];
              tx_head = (tx_head + 1) % TXD;
              tx_count--;
            end else begin
              pend_cnt = 0;
            end
            if (pend_cnt == 0) pend = PEND_NONE;
          end else begin
            pend = PEND_NONE;
            pend_cnt = 0;
          end
        end
        REQ_HPUSH: begin
          if (tx_count < TXD) begin
            tx_store[tx_tail] = b;
            tx_tail = (tx_tail + 1) % TXD;
            tx_count++;
            r.accepted = 1'b1;
          end
        end
        default: begin
          if (rx_count > 0) begin
            r.resp_valid = 1'b1;
            r.resp_data = rx_store[rx_head];
            rx_head = (rx_head + 1) % RXD;
            rx_count--;
          end
        end
      endcase
    end
    r.rx_level = RXW'(rx_count);
    r.tx_level = TXW'(tx_count);
    return r;
  endfunction

  // input driver
  always @(negedge clk_i) begin
    logic took;
    took = (n_xfer != n_seen);
    n_seen = n_xfer;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || took) begin
      if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        req_type_i <= req_q[0].req;
        data_i     <= req_q[0].data;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      resp_q.push_back(bridge_step(req_e'(req_type_i), data_i));
      void'(req_q.pop_front());
      n_xfer++;
    end
  end

  // output side ready, with long hold-offs on request
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (hold_req != hold_done) begin
      hold_done++;
      hold_left = LONG_HOLD - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    bridge_resp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (resp_q.size() == 0) begin
        $error("result transfer with no request outstanding");
        errors++;
      end else begin
        want = resp_q.pop_front();
        if (resp_valid_o !== want.resp_valid) begin
          $error("resp_valid: expected %0d, got %0d", want.resp_valid, resp_valid_o);
          errors++;
        end
        if (resp_data_o !== want.resp_data) begin
          $error("resp_data: expected 0x%02h, got 0x%02h", want.resp_data, resp_data_o);
          errors++;
        end
        if (accepted_o !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, accepted_o);
          errors++;
        end
        if (cmd_error_o !== want.cmd_error) begin
          $error("cmd_error: expected %0d, got %0d", want.cmd_error, cmd_error_o);
          errors++;
        end
        if (rx_level_o !== want.rx_level) begin
          $error("rx_level: expected %0d, got %0d", want.rx_level, rx_level_o);
          errors++;
        end
        if (tx_level_o !== want.tx_level) begin
          $error("tx_level: expected %0d, got %0d", want.tx_level, tx_level_o);
          errors++;
        end
      end
    end
  end

  task automatic put(req_e req, logic [7:0] b);
    bridge_req_t it;
    it.req = req;
    it.data = b;
    req_q.push_back(it);
    n_queued++;
  endtask

  task automatic put_cmd(logic [7:0] c);
    put(REQ_MWRITE, PREFIX_BYTE);
    put(REQ_MWRITE, c);
  endtask

  task automatic put_len(int len);
    put(REQ_MWRITE, 8'(len >> 8));
    put(REQ_MWRITE, 8'(len));
  endtask

  task automatic wait_idle();
    do @(posedge clk_i); while (req_q.size() != 0 || resp_q.size() != 0);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [31:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(4 * REG_ENABLE);
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    enabled = v[0];
    if (!enabled) begin
      phase = PH_PREFIX;
      frame_len = '0;
      pend = PEND_NONE;
      pend_cnt = 0;
      avail_snap = '0;
      rx_head = 0; rx_tail = 0; rx_count = 0;
      tx_head = 0; tx_tail = 0; tx_count = 0;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic queue_mixed_traffic(int n);
    int unsigned base;
    int kind, len, cnt;
    base = n_queued;
    while (n_queued - base < n) begin
      kind = $urandom_range(99);
      if (kind < 18) begin
        repeat ($urandom_range(1, 8)) put(REQ_HPUSH, 8'($urandom_range(255)));
      end else if (kind < 34) begin
        put_cmd(CMD_READ);
        len = ($urandom_range(9) == 0) ? $urandom_range(16'hFFFF) : $urandom_range(12);
        put_len(len);
        repeat ($urandom_range(14)) put(REQ_MREAD, 8'($urandom_range(255)));
      end else if (kind < 50) begin
        put_cmd(CMD_WRITE);
        len = $urandom_range(12);
        put_len(len);
        // occasionally a short frame, so later bytes land as payload
        cnt = ($urandom_range(7) == 0) ? $urandom_range(len) : len;
        repeat (cnt) put(REQ_MWRITE, 8'($urandom_range(255)));
      end else if (kind < 58) begin
        put_cmd(CMD_AVAIL);
        repeat ($urandom_range(3)) put(REQ_MREAD, 8'($urandom_range(255)));
      end else if (kind < 63) begin
        put_cmd(8'($urandom_range(255)));
      end else if (kind < 78) begin
        repeat ($urandom_range(1, 6)) put(REQ_HPOP, 8'($urandom_range(255)));
      end else if (kind < 81) begin
        put_cmd(CMD_RESET);
      end else begin
        repeat ($urandom_range(1, 4)) put(req_e'($urandom_range(3)), 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // disabled: everything ignored
    repeat (8) put(req_e'($urandom_range(3)), 8'($urandom_range(255)));
    wait_idle();
    reg_write(32'd1);

    put(REQ_HPOP, 8'h00);
    put(REQ_MREAD, 8'hFF);
    put(REQ_MWRITE, 8'hFF);
    put_cmd(8'hFF);
    put(REQ_HPUSH, 8'h00);
    put(REQ_HPUSH, 8'hFF);
    put_cmd(CMD_AVAIL);
    put(REQ_MREAD, 8'h00);
    put(REQ_MREAD, 8'h00);
    put_cmd(CMD_READ);
    put_len(16'h0100);
    repeat (3) put(REQ_MREAD, 8'h00);
    put_cmd(CMD_READ);
    put_len(5);
    put_cmd(CMD_WRITE);
    put_len(0);
    put_cmd(CMD_WRITE);
    put_len(2);
    put(REQ_MWRITE, 8'h00);
    put(REQ_MWRITE, 8'hFF);
    put(REQ_HPOP, 8'h00);
    put_cmd(CMD_RESET);
    wait_idle();

    send_idle_pct = 14;
    recv_idle_pct = 57;
    queue_mixed_traffic(450);
    do @(posedge clk_i); while (req_q.size() > 300);
    hold_req++;
    wait_idle();

    reg_write(32'd1);
    reg_write(32'd0);
    repeat (4) put(req_e'($urandom_range(3)), 8'($urandom_range(255)));
    wait_idle();
    reg_write(32'd1);

    send_idle_pct = 57;
    recv_idle_pct = 14;
    queue_mixed_traffic(250);
    wait_idle();
    queue_mixed_traffic(200);
    wait_idle();

    reg_write(32'd0);
    reg_write(32'hFFFF_FFFF);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // short TX fill, then drain it through AVAIL and a long READ
    for (int i = 0; i < 12; i++) put(REQ_HPUSH, 8'(i));
    put_cmd(CMD_AVAIL);
    repeat (2) put(REQ_MREAD, 8'h00);
    put_cmd(CMD_READ);
    put_len(16'hFFFF);
    repeat (14) put(REQ_MREAD, 8'h00);
    put_cmd(CMD_WRITE);
    put_len(3);
    repeat (3) put(REQ_MWRITE, 8'($urandom_range(255)));
    repeat (2) put(REQ_HPOP, 8'h00);
    put_cmd(CMD_RESET);
    put(REQ_HPOP, 8'h00);
    queue_mixed_traffic(100);
    wait_idle();

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/i2cb_pkg.sv
rtl/core/i2cb_front.sv
rtl/core/i2cb_exec.sv
rtl/core/i2cb_outq.sv
rtl/core/i2c_slave_command_fifo_bridge_top.sv
verif/i2c_slave_command_fifo_bridge_top_test.sv
